// ===== hw/rtl/mtpl_pkg.sv =====
// ============================================================================
// mtpl_pkg
// Shared types and constants of the multibit trie prefix lookup block.
// ============================================================================
package mtpl_pkg;

    // Default sizing
    localparam int NODE_POOL_DEF = 4096;
    localparam int HOP_BITS_DEF  = 16;

    // Trie geometry: 16-bit top stride, then four 4-bit strides
    localparam int TOP_BUCKETS = 65536;
    localparam int SUB_BUCKETS = 16;

    typedef enum logic [2:0] {
        CMD_LOOKUP   = 3'd0,
        CMD_INSERT   = 3'd1,
        CMD_REPLACE  = 3'd2,
        CMD_REMOVE   = 3'd3,
        CMD_FLUSH    = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXISTS    = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_POOL_FULL = 2'd3
    } t_status;

endpackage

// ===== hw/rtl/multibit_trie_prefix_lookup.sv =====
// ============================================================================
// multibit_trie_prefix_lookup
// IPv4 longest-prefix-match table held as a multibit trie (strides
// 16,4,4,4,4) in one entry memory, with insert, replace, remove and flush.
// ============================================================================
//
// Usage:
//   A transaction is accepted at a rising edge with start high and busy low.
//   Fields i_command, i_address, i_prefix_length and i_next_hop are sampled
//   then. Exactly one result per transaction appears on o_hop_out/o_status
//   for one cycle with o_done high; the receiver cannot stall it.
//   Lookup: the walk reads one trie level at a time, each read addressed by
//   the link that the registered entry memory returned for the level above.
//   Default-route insert/remove and unused commands answer from idle.
//   Insert/remove: the walk, a read of the prefix slot and one of its parent,
//   then a read per slot of the covered subtree, with a write-back where the old
//   id is found, while ids are expanded (up to 65535 slots in the top node).
//   Flush and reset run a clearing pass over all 65536 + 16*NODE_POOL
//   memory entries, one per cycle (131072 at defaults), with busy high;
//   a flush reports its result when the pass ends, reset reports nothing.
//   busy drops in the same cycle the result is shown, so the next
//   transaction can be accepted while o_done is high.
//
module multibit_trie_prefix_lookup #(
    parameter int NODE_POOL = mtpl_pkg::NODE_POOL_DEF,
    parameter int HOP_BITS  = mtpl_pkg::HOP_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_command,
    input  logic [31:0] i_address,
    input  logic [5:0]  i_prefix_length,
    input  logic [15:0] i_next_hop,
    output logic        o_done,
    output logic [15:0] o_hop_out,
    output logic [1:0]  o_status
);
    import mtpl_pkg::*;

    localparam int HW    = HOP_BITS;
    localparam int LW    = $clog2(NODE_POOL);
    localparam int NW    = $clog2(NODE_POOL + 1);
    localparam int WW    = 2 * HW + LW;
    localparam int DEPTH = TOP_BUCKETS + NODE_POOL * SUB_BUCKETS;
    localparam int AW    = $clog2(DEPTH);

    typedef struct packed {
        logic [HW-1:0] inner;
        logic [HW-1:0] leaf;
        logic [LW-1:0] link;
    } t_entry;

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_WALK   = 8'b0000_0100,
        S_SLOT   = 8'b0000_1000,
        S_PARENT = 8'b0001_0000,
        S_SW_RD  = 8'b0010_0000,
        S_SW_WR  = 8'b0100_0000,
        S_REREAD = 8'b1000_0000
    } t_state;

    // ------------------------------------------------------------------
    // Address helpers
    // ------------------------------------------------------------------
    function automatic logic [AW-1:0] f_entry(input logic top, input logic [LW-1:0] node,
                                              input logic [15:0] ent);
        logic [AW-1:0] a;
        if (top) begin
            a = AW'(ent);
        end else begin
            a = AW'(TOP_BUCKETS) + AW'({node, ent[3:0]});
        end
        return a;
    endfunction

    function automatic logic f_is_leaf(input logic top, input logic [16:0] x);
        return top ? x[16] : x[4];
    endfunction

    function automatic logic [AW-1:0] f_slot_entry(input logic top, input logic [LW-1:0] node,
                                                   input logic [16:0] x);
        return f_entry(top, node, top ? x[15:0] : {12'd0, x[3:0]});
    endfunction

    function automatic logic [HW-1:0] f_field(input t_entry w, input logic top,
                                              input logic [16:0] x);
        return f_is_leaf(top, x) ? w.leaf : w.inner;
    endfunction

    function automatic logic [15:0] f_idx(input logic [2:0] lvl, input logic [31:0] addr);
        logic [15:0] v;
        unique case (lvl)
            3'd0:    v = addr[31:16];
            3'd1:    v = {12'd0, addr[15:12]};
            3'd2:    v = {12'd0, addr[11:8]};
            3'd3:    v = {12'd0, addr[7:4]};
            default: v = {12'd0, addr[3:0]};
        endcase
        return v;
    endfunction

    // Prefix length covered up to the end of this level's stride
    function automatic logic [5:0] f_thr(input logic [2:0] lvl);
        return 6'd16 + 6'({lvl, 2'b00});
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state        r_state, n_state;
    t_cmd          r_cmd, n_cmd;
    logic [31:0]   r_addr, n_addr;
    logic [5:0]    r_plen, n_plen;
    logic [HW-1:0] r_hop, n_hop;
    logic [2:0]    r_lvl, n_lvl;
    logic [LW-1:0] r_node, n_node;
    logic [NW-1:0] r_free, n_free;
    logic [HW-1:0] r_default, n_default;
    logic [HW-1:0] r_cur, n_cur;
    logic [16:0]   r_i1, n_i1;
    logic [HW-1:0] r_rep, n_rep;
    logic [HW-1:0] r_key, n_key;
    logic [HW-1:0] r_prev, n_prev;
    logic          r_pass2, n_pass2;
    logic [16:0]   r_lo, n_lo;
    logic [16:0]   r_hi, n_hi;
    logic [16:0]   r_x, n_x;
    logic [AW-1:0] r_clr, n_clr;
    logic          r_flush, n_flush;
    logic          r_done, n_done;
    logic [15:0]   r_hop_out, n_hop_out;
    t_status       r_status, n_status;

    // Memory port
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [WW-1:0] ram_wdata, ram_rdata;

    // Datapath helpers
    t_entry        w_word, w_link_word, w_sweep_word;
    logic          w_top;
    logic [5:0]    w_plen, w_thr;
    logic [HW-1:0] w_in_hop;
    logic [15:0]   w_idx, w_idx_next;
    logic [16:0]   w_slot;
    logic [HW-1:0] w_pv, w_prev, w_key, w_res;
    logic          w_set, w_go, w_end, w_is_ins;

    assign w_word   = t_entry'(ram_rdata);
    assign w_top    = (r_lvl == 3'd0);
    assign w_plen   = (i_prefix_length > 6'd32) ? 6'd32 : i_prefix_length;
    assign w_in_hop = HW'(i_next_hop);
    assign w_thr    = f_thr(r_lvl);
    assign w_idx    = f_idx(r_lvl, r_addr);
    assign w_idx_next = f_idx(3'(r_lvl + 3'd1), r_addr);
    assign w_is_ins = (r_cmd == CMD_INSERT) || (r_cmd == CMD_REPLACE);

    // Slot of the prefix inside the node of its level
    always_comb begin
        logic [16:0] v;
        logic [4:0]  sh;
        v  = w_top ? {1'b1, r_addr[31:16]} : {12'd0, 1'b1, w_idx[3:0]};
        sh = 5'(w_thr - r_plen);
        w_slot = v >> sh;
    end

    // Decide whether the prefix id gets expanded over its subtree
    always_comb begin
        w_pv   = f_field(w_word, w_top, r_i1 >> 1);
        w_prev = r_rep;
        if (r_rep != '0 && r_i1 > 17'd3 && w_pv == r_rep) begin
            w_prev = '0;
        end
        w_key = w_is_ins ? r_hop : '0;
        if (w_key == '0 && r_i1 > 17'd3) begin
            w_key = w_pv;
        end
        w_set = (r_cmd == CMD_REPLACE) || r_pass2;
        w_go  = (w_prev != w_key) && (w_prev == '0 || w_set);
        w_res = (r_state == S_PARENT && !r_pass2) ? w_prev : r_prev;
    end

    // Write-back words: new child link, and swept slot with the new id
    always_comb begin
        w_link_word      = w_word;
        w_link_word.link = LW'(r_free);
        w_sweep_word     = w_word;
        if (f_is_leaf(w_top, r_x)) begin
            w_sweep_word.leaf = r_key;
        end else begin
            w_sweep_word.inner = r_key;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_addr    = r_addr;
        n_plen    = r_plen;
        n_hop     = r_hop;
        n_lvl     = r_lvl;
        n_node    = r_node;
        n_free    = r_free;
        n_default = r_default;
        n_cur     = r_cur;
        n_i1      = r_i1;
        n_rep     = r_rep;
        n_key     = r_key;
        n_prev    = r_prev;
        n_pass2   = r_pass2;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_x       = r_x;
        n_clr     = r_clr;
        n_flush   = r_flush;
        n_done    = 1'b0;
        n_hop_out = r_hop_out;
        n_status  = r_status;
        ram_we    = 1'b0;
        ram_waddr = r_clr;
        ram_wdata = '0;
        ram_raddr = '0;
        w_end     = 1'b0;

        unique case (r_state)
            // Zero every entry, one per cycle
            S_CLEAR: begin
                ram_we = 1'b1;
                n_clr  = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_clr   = '0;
                    n_state = S_IDLE;
                    if (r_flush) begin
                        n_done    = 1'b1;
                        n_hop_out = '0;
                        n_status  = ST_OK;
                    end
                    n_flush = 1'b0;
                end
            end

            // Accept a transaction and start the top-level read
            S_IDLE: begin
                ram_raddr = f_entry(1'b1, '0, i_address[31:16]);
                if (start) begin
                    n_cmd   = t_cmd'(i_command);
                    n_addr  = i_address;
                    n_plen  = w_plen;
                    n_hop   = w_in_hop;
                    n_lvl   = '0;
                    n_node  = '0;
                    n_cur   = r_default;
                    n_pass2 = 1'b0;
                    n_prev  = '0;
                    unique case (t_cmd'(i_command))
                        CMD_LOOKUP: begin
                            n_state = S_WALK;
                        end
                        CMD_INSERT, CMD_REPLACE: begin
                            if (w_plen == '0) begin
                                n_done    = 1'b1;
                                n_hop_out = 16'(r_default);
                                n_status  = ST_OK;
                                if (r_default == '0 || i_command == CMD_REPLACE) begin
                                    n_default = w_in_hop;
                                end
                                if (r_default != '0 && i_command != CMD_REPLACE) begin
                                    n_status = ST_EXISTS;
                                end
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        CMD_REMOVE: begin
                            if (w_plen == '0) begin
                                n_done    = 1'b1;
                                n_hop_out = 16'(r_default);
                                n_default = '0;
                                n_status  = (r_default != '0) ? ST_OK : ST_NOT_FOUND;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        CMD_FLUSH: begin
                            n_default = '0;
                            n_free    = NW'(1);
                            n_clr     = '0;
                            n_flush   = 1'b1;
                            n_state   = S_CLEAR;
                        end
                        default: begin
                            n_done    = 1'b1;
                            n_hop_out = '0;
                            n_status  = ST_OK;
                        end
                    endcase
                end
            end

            // One trie level per cycle
            S_WALK: begin
                if (r_cmd == CMD_LOOKUP) begin
                    if (w_word.leaf != '0) begin
                        n_cur = w_word.leaf;
                    end
                    if (w_word.link == '0 || r_lvl == 3'd4) begin
                        n_done    = 1'b1;
                        n_hop_out = 16'((w_word.leaf != '0) ? w_word.leaf : r_cur);
                        n_status  = ST_OK;
                        n_state   = S_IDLE;
                    end else begin
                        n_lvl     = r_lvl + 3'd1;
                        n_node    = w_word.link;
                        ram_raddr = f_entry(1'b0, w_word.link, w_idx_next);
                    end
                end else if (r_lvl != 3'd4 && r_plen > w_thr) begin
                    if (w_word.link != '0) begin
                        n_lvl     = r_lvl + 3'd1;
                        n_node    = w_word.link;
                        ram_raddr = f_entry(1'b0, w_word.link, w_idx_next);
                    end else if (r_cmd == CMD_REMOVE) begin
                        n_done    = 1'b1;
                        n_hop_out = '0;
                        n_status  = ST_NOT_FOUND;
                        n_state   = S_IDLE;
                    end else if (r_free >= NW'(NODE_POOL)) begin
                        n_done    = 1'b1;
                        n_hop_out = '0;
                        n_status  = ST_POOL_FULL;
                        n_state   = S_IDLE;
                    end else begin
                        // allocate a child node and descend into it
                        ram_we    = 1'b1;
                        ram_waddr = f_entry(w_top, r_node, w_idx);
                        ram_wdata = w_link_word;
                        n_free    = r_free + NW'(1);
                        n_lvl     = r_lvl + 3'd1;
                        n_node    = LW'(r_free);
                        ram_raddr = f_entry(1'b0, LW'(r_free), w_idx_next);
                    end
                end else begin
                    n_i1      = w_slot;
                    ram_raddr = f_slot_entry(w_top, r_node, w_slot);
                    n_state   = S_SLOT;
                end
            end

            // Capture the slot's id, fetch its parent
            S_SLOT: begin
                n_rep     = f_field(w_word, w_top, r_i1);
                ram_raddr = f_slot_entry(w_top, r_node, r_i1 >> 1);
                n_state   = S_PARENT;
            end

            S_PARENT: begin
                n_key = w_key;
                if (!r_pass2) begin
                    n_prev = w_prev;
                end
                if (w_go) begin
                    n_lo    = r_i1;
                    n_hi    = r_i1;
                    n_x     = r_i1;
                    n_state = S_SW_RD;
                end else begin
                    w_end = 1'b1;
                end
            end

            S_SW_RD: begin
                ram_raddr = f_slot_entry(w_top, r_node, r_x);
                n_state   = S_SW_WR;
            end

            // Replace the old id in this slot, advance through the subtree
            S_SW_WR: begin
                if (f_field(w_word, w_top, r_x) == r_rep) begin
                    ram_we    = 1'b1;
                    ram_waddr = f_slot_entry(w_top, r_node, r_x);
                    ram_wdata = w_sweep_word;
                end
                n_state = S_SW_RD;
                if (r_x == r_hi) begin
                    if (f_is_leaf(w_top, r_lo)) begin
                        w_end = 1'b1;
                    end else begin
                        n_lo = r_lo << 1;
                        n_hi = (r_hi << 1) | 17'd1;
                        n_x  = r_lo << 1;
                    end
                end else begin
                    n_x = r_x + 17'd1;
                end
            end

            // Fetch the slot again after any write-back has landed
            S_REREAD: begin
                ram_raddr = f_slot_entry(w_top, r_node, r_i1);
                n_state   = S_SLOT;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Close one update pass
        if (w_end) begin
            n_state = S_IDLE;
            if (w_is_ins) begin
                n_done    = 1'b1;
                n_hop_out = 16'(w_res);
                n_status  = (w_res != '0 && r_cmd != CMD_REPLACE) ? ST_EXISTS : ST_OK;
            end else if (!r_pass2) begin
                if (w_res == '0) begin
                    n_done    = 1'b1;
                    n_hop_out = '0;
                    n_status  = ST_NOT_FOUND;
                end else begin
                    n_pass2 = 1'b1;
                    n_state = S_REREAD;
                end
            end else begin
                n_done    = 1'b1;
                n_hop_out = 16'(r_prev);
                n_status  = ST_OK;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_free    <= NW'(1);
            r_default <= '0;
            r_clr     <= '0;
            r_flush   <= 1'b0;
            r_done    <= 1'b0;
            r_pass2   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_free    <= n_free;
            r_default <= n_default;
            r_clr     <= n_clr;
            r_flush   <= n_flush;
            r_done    <= n_done;
            r_pass2   <= n_pass2;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_addr    <= n_addr;
        r_plen    <= n_plen;
        r_hop     <= n_hop;
        r_lvl     <= n_lvl;
        r_node    <= n_node;
        r_cur     <= n_cur;
        r_i1      <= n_i1;
        r_rep     <= n_rep;
        r_key     <= n_key;
        r_prev    <= n_prev;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_x       <= n_x;
        r_hop_out <= n_hop_out;
        r_status  <= n_status;
    end

    // Entry memory: top node buckets, then the node pool
    mtpl_ram #(
        .WIDTH (WW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy      = (r_state != S_IDLE);
    assign o_done    = r_done;
    assign o_hop_out = r_hop_out;
    assign o_status  = r_status;

endmodule

// ===== hw/rtl/mtpl_ram.sv =====
// ============================================================================
// mtpl_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ============================================================================
module mtpl_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/mtpl_checker.sv =====
// ============================================================================
// mtpl_checker
// Port-level checks of the prefix lookup block, bound to its top level.
// ============================================================================
module mtpl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [15:0] o_hop_out,
    input logic [1:0]  o_status
);
    import mtpl_pkg::*;

    // Results come out only when the block is free again
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while busy");

    // An accepted transaction either finishes at once or keeps the block busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted transaction vanished");

    // Not-found and pool-full report no id
    a_fail_no_hop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_NOT_FOUND || o_status == ST_POOL_FULL))
        |-> (o_hop_out == 16'd0))
        else $error("failure status with nonzero id");

    // An existing route always reports its id
    a_exists_hop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_EXISTS) |-> (o_hop_out != 16'd0))
        else $error("exists status without id");

endmodule

bind multibit_trie_prefix_lookup mtpl_checker u_mtpl_checker (.*);
